### hw/rtl/tfs_pkg.sv
// Shared types and constants for the tagged-field section skipper.
package tfs_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LONG  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [2:0] LAST_GROUP = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } t_byte_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] fields_seen;
        logic [31:0] last_tag;
    } t_result;

    typedef struct packed {
        logic advance;
        logic load;
    } t_core_ctl;

endpackage

### hw/rtl/tfs_if.sv
// Byte stream and result channel interfaces.
interface tfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface tfs_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] fields_seen;
    logic [31:0] last_tag;

    modport source (output valid, output status, output fields_seen, output last_tag,
                    input ready);
    modport sink   (input valid, input status, input fields_seen, input last_tag,
                    output ready);
endinterface

### hw/rtl/tagged_field_section_skipper.sv
// Tagged-field section skipper: one byte per cycle, one result per section.
// Bytes enter an input register, the section state (count, tag, size, payload
// skip) advances one byte at a time and the outcome lands in a result register.
// A byte can be taken every cycle but for the stall below; it passes the input
// register, then the result register. The byte that completes a section or
// raises an error (overlong varint, tags not increasing, frame ended early)
// yields one result transaction with status, fields parsed and the last
// decoded tag; the next byte starts a new section. Input stalls only while a
// result is waiting and the next byte would produce another one.
module tagged_field_section_skipper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfs_byte_if.sink      i_byte,
    tfs_result_if.source  o_result
);
    import tfs_pkg::*;

    t_core_ctl  ctl;
    logic       item_valid;
    t_byte_item item;
    t_result    result;
    logic       slot_free;

    tfs_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_ctl   (ctl),
        .o_valid (item_valid),
        .o_item  (item)
    );

    tfs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_item      (item),
        .i_slot_free (slot_free),
        .o_ctl       (ctl),
        .o_result    (result)
    );

    tfs_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_result    (result),
        .o_slot_free (slot_free),
        .o_result    (o_result)
    );
endmodule

### hw/rtl/tfs_in_stage.sv
// Input register for the byte stream.
module tfs_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tfs_byte_if.sink            i_byte,
    input  tfs_pkg::t_core_ctl  i_ctl,
    output logic                o_valid,
    output tfs_pkg::t_byte_item o_item
);
    import tfs_pkg::*;

    logic       r_valid;
    t_byte_item r_item;

    assign i_byte.ready = !r_valid || i_ctl.advance;
    assign o_valid      = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_item.data_byte  <= i_byte.data_byte;
            r_item.frame_last <= i_byte.frame_last;
        end
    end
endmodule

### hw/rtl/tfs_core.sv
// Section parse state and its next-state logic.
module tfs_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  tfs_pkg::t_byte_item i_item,
    input  logic                i_slot_free,
    output tfs_pkg::t_core_ctl  o_ctl,
    output tfs_pkg::t_result    o_result
);
    import tfs_pkg::*;

    typedef enum logic [1:0] {PH_COUNT, PH_TAG, PH_SIZE, PH_SKIP} t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_accum, n_accum;
    logic [2:0]  r_group, n_group;
    logic [31:0] r_fields_left, n_fields_left;
    logic [31:0] r_field_index, n_field_index;
    logic [31:0] r_prev_tag, n_prev_tag;
    logic [31:0] r_skip_left, n_skip_left;

    logic [31:0] grp;
    logic [31:0] value;
    logic        bad;
    logic        fin;
    logic [1:0]  st;
    logic [6:0]  bits;

    assign bits = i_item.data_byte[6:0];

    always_comb begin
        case (r_group)
            3'd0:    grp = {25'd0, bits};
            3'd1:    grp = {18'd0, bits, 7'd0};
            3'd2:    grp = {11'd0, bits, 14'd0};
            3'd3:    grp = {4'd0, bits, 21'd0};
            default: grp = {bits[3:0], 28'd0};
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_accum       = r_accum;
        n_group       = r_group;
        n_fields_left = r_fields_left;
        n_field_index = r_field_index;
        n_prev_tag    = r_prev_tag;
        n_skip_left   = r_skip_left;
        value         = r_accum | grp;
        bad           = 1'b0;
        fin           = 1'b0;
        st            = ST_OK;

        if (r_phase == PH_SKIP) begin
            n_skip_left = r_skip_left - 32'd1;
            if (n_skip_left == 32'd0) begin
                n_field_index = r_field_index + 32'd1;
                n_fields_left = r_fields_left - 32'd1;
                if (n_fields_left == 32'd0) begin
                    fin = 1'b1;
                end else begin
                    n_phase = PH_TAG;
                end
            end
        end else if (i_item.data_byte[7]) begin
            n_accum = value;
            if (r_group >= LAST_GROUP) begin
                fin = 1'b1;
                st  = ST_LONG;
            end else begin
                n_group = r_group + 3'd1;
            end
        end else begin
            n_accum = 32'd0;
            n_group = 3'd0;
            case (r_phase)
                PH_COUNT: begin
                    n_fields_left = value;
                    n_field_index = 32'd0;
                    if (value == 32'd0) begin
                        fin = 1'b1;
                    end else begin
                        n_phase = PH_TAG;
                    end
                end
                PH_TAG: begin
                    bad        = (r_field_index != 32'd0) && (value <= r_prev_tag);
                    n_prev_tag = value;
                    if (bad) begin
                        fin = 1'b1;
                        st  = ST_ORDER;
                    end else begin
                        n_phase = PH_SIZE;
                    end
                end
                default: begin
                    n_skip_left = value;
                    if (value == 32'd0) begin
                        n_field_index = r_field_index + 32'd1;
                        n_fields_left = r_fields_left - 32'd1;
                        if (n_fields_left == 32'd0) begin
                            fin = 1'b1;
                        end else begin
                            n_phase = PH_TAG;
                        end
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            endcase
        end

        if (!fin && i_item.frame_last) begin
            fin = 1'b1;
            st  = ST_TRUNC;
        end

        o_result.status      = st;
        o_result.fields_seen = n_field_index;
        o_result.last_tag    = n_prev_tag;

        if (fin) begin
            n_phase       = PH_COUNT;
            n_accum       = 32'd0;
            n_group       = 3'd0;
            n_fields_left = 32'd0;
            n_field_index = 32'd0;
            n_prev_tag    = 32'd0;
            n_skip_left   = 32'd0;
        end
    end

    assign o_ctl.advance = i_valid && (!fin || i_slot_free);
    assign o_ctl.load    = i_valid && fin && i_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_COUNT;
            r_accum       <= 32'd0;
            r_group       <= 3'd0;
            r_fields_left <= 32'd0;
            r_field_index <= 32'd0;
            r_prev_tag    <= 32'd0;
            r_skip_left   <= 32'd0;
        end else if (o_ctl.advance) begin
            r_phase       <= n_phase;
            r_accum       <= n_accum;
            r_group       <= n_group;
            r_fields_left <= n_fields_left;
            r_field_index <= n_field_index;
            r_prev_tag    <= n_prev_tag;
            r_skip_left   <= n_skip_left;
        end
    end
endmodule

### hw/rtl/tfs_out_stage.sv
// Result register driving the result channel.
module tfs_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tfs_pkg::t_core_ctl i_ctl,
    input  tfs_pkg::t_result   i_result,
    output logic               o_slot_free,
    tfs_result_if.source       o_result
);
    import tfs_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_slot_free          = !r_valid || o_result.ready;
    assign o_result.valid       = r_valid;
    assign o_result.status      = r_result.status;
    assign o_result.fields_seen = r_result.fields_seen;
    assign o_result.last_tag    = r_result.last_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_result <= i_result;
        end
    end
endmodule

### hw/rtl/tfs_checker.sv
// Port-level assertions for the tagged-field section skipper, with bind.
module tfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [31:0] i_fields_seen,
    input logic [31:0] i_last_tag
);
    import tfs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
        && $stable(i_fields_seen) && $stable(i_last_tag))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no result pending");

    a_order_needs_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_ORDER) |-> (i_fields_seen != 32'd0))
        else $error("tag order error before any field");

    a_empty_ok_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OK) && (i_fields_seen == 32'd0)
        |-> (i_last_tag == 32'd0))
        else $error("empty section reports a tag");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");
endmodule

bind tagged_field_section_skipper tfs_checker u_tfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_byte.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_fields_seen (o_result.fields_seen),
    .i_last_tag    (o_result.last_tag)
);
